// ----- src/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// Field widths, command and status codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ADDR_W          = 32;
	localparam int BYTES_W         = 25;
	localparam int COUNT_W         = 5;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int BLOCK_SLOTS_DEF = 16;

	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = BYTES_W'(256);
	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(16);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EXHAUSTED   = 2'd1,
		ST_NOT_FOUND   = 2'd2,
		ST_DOUBLE_FREE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_ADDRESS = 2'd0,
		REG_BLOCK_BYTES  = 2'd1,
		REG_BLOCK_COUNT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic rebuild;
		logic pop;
		logic push;
	} list_op_t;

endpackage

// ----- src/fbpa_if.sv -----
// ----------------------------------------------------------------------------
// fbpa_if: request and response channels of the block pool allocator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface fbpa_req_if
	import fbpa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output cmd, output address, input ready);
	modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface fbpa_rsp_if
	import fbpa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  block_address;
	logic [COUNT_W-1:0] used_count;
	logic [COUNT_W-1:0] free_count;

	modport source (output valid, output status, output block_address,
		output used_count, output free_count, input ready);
	modport sink   (input valid, input status, input block_address,
		input used_count, input free_count, output ready);
endinterface

// ----- src/fbpa_list.sv -----
// ----------------------------------------------------------------------------
// fbpa_list: LIFO free list with per-block in-use marks
// Link memory with valid bits (unwritten entry i links to i+1), head pointer.
// ----------------------------------------------------------------------------
module fbpa_list
	import fbpa_pkg::*;
#(
	parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF,
	parameter int PW = $clog2(BLOCK_SLOTS + 1),
	parameter int AW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  list_op_t      op,
	input  logic [PW-1:0] end_ptr,
	input  logic [AW-1:0] query_idx,
	output logic [PW-1:0] head,
	output logic          query_in_use
);

	logic [PW-1:0]          nf_mem [BLOCK_SLOTS];
	logic [PW-1:0]          rd_q;
	logic [BLOCK_SLOTS-1:0] nf_vld_q;
	logic [BLOCK_SLOTS-1:0] in_use_q;
	logic [PW-1:0]          head_q;
	logic [AW-1:0]          head_idx;
	logic [PW-1:0]          next_head;

	assign head_idx     = head_q[AW-1:0];
	assign next_head    = nf_vld_q[head_idx] ? rd_q : head_q + PW'(1);
	assign head         = head_q;
	assign query_in_use = in_use_q[query_idx];

	always_ff @(posedge clk) begin
		if (op.pop) begin
			nf_mem[head_idx] <= end_ptr;
		end else if (op.push) begin
			nf_mem[query_idx] <= head_q;
		end
		rd_q <= nf_mem[head_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_vld_q <= '0;
			in_use_q <= '0;
			head_q   <= '0;
		end else if (op.rebuild) begin
			nf_vld_q <= '0;
			in_use_q <= '0;
			head_q   <= '0;
		end else if (op.pop) begin
			nf_vld_q[head_idx] <= 1'b1;
			in_use_q[head_idx] <= 1'b1;
			head_q             <= next_head;
		end else if (op.push) begin
			nf_vld_q[query_idx] <= 1'b1;
			in_use_q[query_idx] <= 1'b0;
			head_q              <= PW'(query_idx);
		end
	end

	a_pop_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.pop && op.push))
		else $error("pop and push in the same cycle");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> (head_q < end_ptr))
		else $error("pop from empty free list");

	a_push_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		op.push |-> in_use_q[query_idx])
		else $error("push of a block not in use");

	a_pop_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(op.pop && !op.rebuild) |=> in_use_q[$past(head_idx)])
		else $error("popped block not marked in use");

endmodule

// ----- src/fixed_block_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with LIFO free list
// Allocates and frees equal blocks at base + index * block size.
//
// Usage: req carries cmd (alloc/free) and address (for free); rsp returns
// status, block_address, used_count and free_count, one response per request.
// Config: cfg_we with cfg_index 0..2 writes base, block size or block count
// and rebuilds the list with every block free; write only while idle.
// Alloc steps from the request transfer to the response: accept/link read,
// pop, result; an exhausted alloc or a free of address zero goes to result.
// Free walks the block addresses with one shared adder and comparator, one
// block per cycle, until a match or the last of the N effective blocks.
// req.ready is high only while idle, so a new request is taken only once the
// last result is loaded. A finished response sits in the output register;
// the next request is taken while it waits, and that request's result holds
// back until rsp is free. Reset clears the list (all blocks free, head at
// block zero) and loads base 0, block size 256, block count 16; no clearing
// pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int BLOCK_SLOTS = BLOCK_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	fbpa_req_if.sink              req,
	fbpa_rsp_if.source            rsp
);

	localparam int PW = $clog2(BLOCK_SLOTS + 1);
	localparam int AW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
	localparam int MW = PW + BYTES_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_ALLOC,
		S_FREE,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [ADDR_W-1:0]    base_q;
	logic [BYTES_W-1:0]   bytes_q;
	logic [COUNT_W-1:0]   bcount_q;
	logic [PW-1:0]        used_q;
	logic [PW-1:0]        idx_q;
	logic [ADDR_W-1:0]    acc_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    prod_s1;
	status_t              status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic                 out_vld_q;
	status_t              out_status_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [COUNT_W-1:0]   out_used_q;
	logic [COUNT_W-1:0]   out_free_q;

	logic [PW-1:0]        n_eff;
	logic [PW-1:0]        head;
	logic                 query_in_use;
	logic [MW-1:0]        prod_full;
	logic                 req_xfer;
	logic                 rebuild;
	logic                 out_load;
	list_op_t             list_op;

	always_comb begin
		if (bcount_q == '0) begin
			n_eff = PW'(1);
		end else if (int'(bcount_q) > BLOCK_SLOTS) begin
			n_eff = PW'(BLOCK_SLOTS);
		end else begin
			n_eff = PW'(bcount_q);
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_vld_q || rsp.ready);
	assign prod_full = MW'(head) * MW'(bytes_q);

	always_comb begin
		rebuild = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS, REG_BLOCK_BYTES, REG_BLOCK_COUNT: rebuild = 1'b1;
				default: rebuild = 1'b0;
			endcase
		end
	end

	always_comb begin
		list_op.rebuild = rebuild;
		list_op.pop     = (state_q == S_ALLOC);
		list_op.push    = (state_q == S_FREE) && query_in_use;
	end

	fbpa_list #(
		.BLOCK_SLOTS (BLOCK_SLOTS),
		.PW          (PW),
		.AW          (AW)
	) u_list (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (list_op),
		.end_ptr      (n_eff),
		.query_idx    (idx_q[AW-1:0]),
		.head         (head),
		.query_in_use (query_in_use)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			bytes_q  <= BLOCK_BYTES_RST;
			bcount_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS: base_q   <= cfg_wdata[ADDR_W-1:0];
				REG_BLOCK_BYTES:  bytes_q  <= cfg_wdata[BYTES_W-1:0];
				REG_BLOCK_COUNT:  bcount_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ADDR_W'(prod_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_q       <= '0;
			out_vld_q    <= 1'b0;
			idx_q        <= '0;
			acc_q        <= '0;
			addr_q       <= '0;
			status_q     <= ST_OK;
			res_addr_q   <= '0;
			out_status_q <= ST_OK;
			out_addr_q   <= '0;
			out_used_q   <= '0;
			out_free_q   <= '0;
		end else begin
			if (rebuild) begin
				used_q <= '0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						res_addr_q <= '0;
						status_q   <= ST_OK;
						if (req.cmd == CMD_ALLOC) begin
							if (head >= n_eff) begin
								status_q <= ST_EXHAUSTED;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_ALLOC;
							end
						end else begin
							addr_q <= req.address;
							idx_q  <= '0;
							acc_q  <= base_q;
							if (req.address == '0) begin
								status_q <= ST_NOT_FOUND;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SEARCH;
							end
						end
					end
				end
				S_SEARCH: begin
					if (acc_q == addr_q) begin
						state_q <= S_FREE;
					end else if (idx_q == n_eff - PW'(1)) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_q + PW'(1);
						acc_q <= acc_q + ADDR_W'(bytes_q);
					end
				end
				S_ALLOC: begin
					res_addr_q <= base_q + prod_s1;
					used_q     <= used_q + PW'(1);
					state_q    <= S_DONE;
				end
				S_FREE: begin
					if (!query_in_use) begin
						status_q <= ST_DOUBLE_FREE;
					end else if (used_q != '0) begin
						used_q <= used_q - PW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_status_q <= status_q;
						out_addr_q   <= res_addr_q;
						out_used_q   <= COUNT_W'(used_q);
						out_free_q   <= COUNT_W'(n_eff - used_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.used_count    = out_used_q;
	assign rsp.free_count    = out_free_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= n_eff)
		else $error("used count above block count");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req.ready)
		else $error("request taken while busy");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (idx_q < n_eff))
		else $error("search index out of range");

	a_alloc_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |=> (used_q == $past(used_q) + PW'(1)))
		else $error("alloc did not count the block");

endmodule

// ----- verif/tb_fixed_block_pool_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench for the block pool
// Drives allocate and free requests in random bursts against a bit-true
// model of the free list, reprograms base, block size and block count
// between phases, and checks every response field against the model.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
	import fbpa_pkg::*;

	localparam int POOL_N = BLOCK_SLOTS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		cmd_t              op;
		logic [ADDR_W-1:0] addr;
	} pool_req_t;

	typedef struct packed {
		status_t            st;
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] used_count;
		logic [COUNT_W-1:0] free_count;
	} pool_rsp_t;

	bit                    clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	fixed_block_pool_allocator #(.BLOCK_SLOTS(POOL_N)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// pool model state
	logic [ADDR_W-1:0]  cfg_base;
	logic [BYTES_W-1:0] cfg_size;
	logic [COUNT_W-1:0] cfg_blocks;
	bit                 in_use [POOL_N];
	logic [COUNT_W-1:0] link [POOL_N];
	logic [COUNT_W-1:0] head;
	logic [COUNT_W-1:0] used;

	pool_req_t   req_backlog [$];
	pool_rsp_t   answer_q [$];
	pool_req_t   nxt;
	pool_rsp_t   want;
	bit          req_xfer;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_mode;
	int unsigned stall_run;
	int unsigned fail_count;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned eff_blocks();
		if (cfg_blocks == 0)
			return 1;
		if (cfg_blocks > POOL_N)
			return POOL_N;
		return 32'(cfg_blocks);
	endfunction

	function automatic logic [ADDR_W-1:0] blk_addr(int unsigned i);
		return cfg_base + ADDR_W'(i) * ADDR_W'(cfg_size);
	endfunction

	function automatic void pool_rebuild();
		for (int i = 0; i < POOL_N; i++) begin
			in_use[i] = 1'b0;
			link[i]   = COUNT_W'(i + 1);
		end
		head = '0;
		used = '0;
	endfunction

	function automatic pool_rsp_t pool_apply(pool_req_t r);
		int unsigned n;
		int unsigned hit;
		int unsigned h;
		pool_rsp_t   a;
		n      = eff_blocks();
		a.st   = ST_OK;
		a.addr = '0;
		if (r.op == CMD_ALLOC) begin
			if (head >= n) begin
				a.st = ST_EXHAUSTED;
			end else begin
				h         = 32'(head);
				head      = link[h];
				link[h]   = COUNT_W'(n);
				in_use[h] = 1'b1;
				used      = used + 1'b1;
				a.addr    = blk_addr(h);
			end
		end else begin
			hit = n;
			// zero never matches, even when a block sits there
			if (r.addr != '0) begin
				for (int i = 0; i < n; i++) begin
					if (blk_addr(i) == r.addr) begin
						hit = i;
						break;
					end
				end
			end
			if (hit >= n) begin
				a.st = ST_NOT_FOUND;
			end else if (!in_use[hit]) begin
				a.st = ST_DOUBLE_FREE;
			end else begin
				in_use[hit] = 1'b0;
				link[hit]   = head;
				head        = COUNT_W'(hit);
				if (used != 0)
					used = used - 1'b1;
			end
		end
		a.used_count = used;
		a.free_count = COUNT_W'(n - used);
		return a;
	endfunction

	function automatic void queue_req(cmd_t op, logic [ADDR_W-1:0] a);
		pool_req_t r;
		r.op   = op;
		r.addr = a;
		req_backlog.push_back(r);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BASE_ADDRESS: begin
				cfg_base = data;
				pool_rebuild();
			end
			REG_BLOCK_BYTES: begin
				cfg_size = data[BYTES_W-1:0];
				pool_rebuild();
			end
			REG_BLOCK_COUNT: begin
				cfg_blocks = data[COUNT_W-1:0];
				pool_rebuild();
			end
			default: begin
			end
		endcase
	endtask

	// conservative: the last term only clears after the block has gone quiet
	task automatic wait_idle();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || req_ch.valid || answer_q.size() != 0);
	endtask

	task automatic shuffle_config();
		logic [CFG_DATA_W-1:0] d;
		logic [BYTES_W-1:0]    sz;
		logic [COUNT_W-1:0]    nb;
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_SPARE, $urandom);
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 3))
				0: d = '0;
				1: d = '1;
				2: d = 32'hFFFF_FFFF - $urandom_range(0, 4095);
				default: d = $urandom;
			endcase
			write_reg(REG_BASE_ADDRESS, d);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: sz = '0;
				1: sz = BYTES_W'(1);
				2: sz = 25'h100_0000;
				3: sz = '1;
				4: sz = BYTES_W'($urandom_range(1, 64));
				default: sz = BYTES_W'($urandom);
			endcase
			d = $urandom;
			d[BYTES_W-1:0] = sz;
			write_reg(REG_BLOCK_BYTES, d);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: nb = '0;
				1, 2: nb = COUNT_W'($urandom_range(1, 4));
				3: nb = COUNT_W'(POOL_N);
				4: nb = COUNT_W'($urandom_range(POOL_N + 1, 31));
				default: nb = COUNT_W'($urandom_range(5, POOL_N - 1));
			endcase
			d = $urandom;
			d[COUNT_W-1:0] = nb;
			write_reg(REG_BLOCK_COUNT, d);
		end
	endtask

	// mostly frees of real block addresses, so allocs and frees pair up
	task automatic random_items(int unsigned cnt);
		int unsigned       n;
		int unsigned       p_alloc;
		int unsigned       r;
		logic [ADDR_W-1:0] a;
		n       = eff_blocks();
		p_alloc = $urandom_range(25, 70);
		repeat (cnt) begin
			if ($urandom_range(0, 99) < p_alloc) begin
				queue_req(CMD_ALLOC, $urandom);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					a = blk_addr($urandom_range(0, n - 1));
				else if (r < 68)
					a = '0;
				else if (r < 84)
					a = $urandom;
				else
					a = blk_addr($urandom_range(0, n - 1)) + ((r % 2) ? 32'd1 : 32'hFFFF_FFFF);
				queue_req(CMD_FREE, a);
			end
		end
	endtask

	// request side: transfer detection and prediction
	always @(posedge clk) begin
		req_xfer = arst_n && req_ch.valid && req_ch.ready;
		if (req_xfer)
			answer_q.push_back(pool_apply('{op: cmd_t'(req_ch.cmd), addr: req_ch.address}));
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_xfer) begin
			if (gap_left != 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				req_ch.valid   <= 1'b1;
				req_ch.cmd     <= nxt.op;
				req_ch.address <= nxt.addr;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response side: backpressure pattern and checking
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_run  = $urandom_range(16, 160);
		end
		stall_run--;
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			2: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
			default: rsp_ch.ready <= (stall_run % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answer_q.size() == 0) begin
				$error("unexpected response: status %0d block_address %h",
					rsp_ch.status, rsp_ch.block_address);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (rsp_ch.status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.block_address !== want.addr) begin
					$error("block_address: expected %h, got %h", want.addr,
						rsp_ch.block_address);
					fail_count++;
				end
				if (rsp_ch.used_count !== want.used_count) begin
					$error("used_count: expected %0d, got %0d", want.used_count,
						rsp_ch.used_count);
					fail_count++;
				end
				if (rsp_ch.free_count !== want.free_count) begin
					$error("free_count: expected %0d, got %0d", want.free_count,
						rsp_ch.free_count);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("fixed_block_pool_allocator verification failed");
		$finish;
	end

	initial begin
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.cmd     = CMD_ALLOC;
		req_ch.address = '0;
		rsp_ch.ready   = 1'b0;
		cfg_base       = '0;
		cfg_size       = BLOCK_BYTES_RST;
		cfg_blocks     = BLOCK_COUNT_RST;
		pool_rebuild();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset geometry: block 0 at address 0 can never be freed
		queue_req(CMD_FREE, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_FREE, 32'h0000_0000);
		queue_req(CMD_FREE, 32'h0000_0100);
		queue_req(CMD_ALLOC, 32'hFFFF_FFFF);
		queue_req(CMD_FREE, 32'h0000_0100);
		queue_req(CMD_FREE, 32'h0000_0100);
		queue_req(CMD_FREE, 32'h0000_1000);
		wait_idle();

		// spare index must leave the list alone
		write_reg(REG_SPARE, $urandom);
		queue_req(CMD_ALLOC, $urandom);
		wait_idle();

		// count 0 acts as a single block, at the top of the address space
		write_reg(REG_BLOCK_COUNT, 32'h0000_0000);
		write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_FREE, 32'hFFFF_FFFF);
		queue_req(CMD_FREE, 32'hFFFF_FFFF);
		queue_req(CMD_FREE, 32'h0000_00FF);
		wait_idle();

		// zero block size: every block shares one address, lowest index wins
		write_reg(REG_BASE_ADDRESS, 32'h0000_0010);
		write_reg(REG_BLOCK_BYTES, 32'h0000_0000);
		write_reg(REG_BLOCK_COUNT, 32'hFFFF_FFFF);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_FREE, 32'h0000_0010);
		queue_req(CMD_FREE, 32'h0000_0010);
		wait_idle();

		// widest block size, second block wraps onto address zero
		write_reg(REG_BASE_ADDRESS, 32'hFE00_0001);
		write_reg(REG_BLOCK_BYTES, 32'hFFFF_FFFF);
		write_reg(REG_BLOCK_COUNT, 32'h0000_0002);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_ALLOC, 32'h0000_0000);
		queue_req(CMD_FREE, 32'h0000_0000);
		queue_req(CMD_FREE, 32'hFE00_0001);
		wait_idle();

		repeat (16) begin
			shuffle_config();
			random_items(100);
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("fixed_block_pool_allocator verification clean");
		else
			$display("fixed_block_pool_allocator verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/fbpa_pkg.sv
src/fbpa_if.sv
src/fbpa_list.sv
src/fixed_block_pool_allocator.sv
verif/tb_fixed_block_pool_allocator.sv
